/* hw/rtl/pic3d_pkg.sv */
`default_nettype none

package pic3d_pkg;

  // Default coordinate width (two's complement, common fixed-point scale)
  localparam int COORD_WIDTH_DEF = 16;

  // Configuration register index width
  localparam int CFG_IDX_W = 3;

  // Configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 3'd0,
    CFG_START_Y = 3'd1,
    CFG_START_Z = 3'd2,
    CFG_END_X   = 3'd3,
    CFG_END_Y   = 3'd4,
    CFG_END_Z   = 3'd5,
    CFG_RADIUS  = 3'd6
  } cfg_idx_t;

  // Segment part nearest to the point
  typedef enum logic [1:0] {
    RGN_START    = 2'd0,
    RGN_INTERIOR = 2'd1,
    RGN_END      = 2'd2
  } region_t;

endpackage

`default_nettype wire

/* hw/rtl/point_in_capsule_test_top.sv */
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------
// in        | input     | in_valid/in_ready  | in_point_x/y/z (signed)
// out       | output    | out_valid/out_ready| out_inside_res, out_region
// cfg       | input     | cfg_we (no wait)   | cfg_index, cfg_wdata
//
// Six register stages; one point per cycle while the output is not stalled.
// The stage count is set by the interior test: squares, dot products, sums, then
// 4-way split products (two stages) and a final wide add and compare.
// rst_n (synchronous) clears valid bits and all capsule registers to zero.
// A stalled output freezes the whole pipeline; in_ready = !out_valid | out_ready.
module point_in_capsule_test_top
  import pic3d_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input points
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_z,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_inside_res,
  output logic [1:0]                         out_region,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [COORD_WIDTH-1:0]        cfg_wdata
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;       // coordinate difference
  localparam int SW = 2 * CW + 2;   // squares, dot products, sums
  localparam int TW = SW + 1;       // signed projection sum
  localparam int RW = CW - 1;       // radius
  localparam int PW = 2 * SW;       // wide products

  // ---------------------------------------------------------------
  // Capsule registers
  logic signed [CW-1:0] start_r [3];
  logic signed [CW-1:0] end_r   [3];
  logic [RW-1:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      radius_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_START_X: start_r[0] <= cfg_wdata;
        CFG_START_Y: start_r[1] <= cfg_wdata;
        CFG_START_Z: start_r[2] <= cfg_wdata;
        CFG_END_X:   end_r[0]   <= cfg_wdata;
        CFG_END_Y:   end_r[1]   <= cfg_wdata;
        CFG_END_Z:   end_r[2]   <= cfg_wdata;
        CFG_RADIUS:  radius_r   <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline advance and valid chain
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 1: differences P-A, P-B, B-A
  logic signed [CW-1:0] pt [3];
  logic signed [DW-1:0] p1_r [3];
  logic signed [DW-1:0] q1_r [3];
  logic signed [DW-1:0] d1_r [3];

  assign pt[0] = in_point_x;
  assign pt[1] = in_point_y;
  assign pt[2] = in_point_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= DW'(pt[i]) - DW'(start_r[i]);
        q1_r[i] <= DW'(pt[i]) - DW'(end_r[i]);
        d1_r[i] <= DW'(end_r[i]) - DW'(start_r[i]);
      end
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: per-axis squares, projection terms, radius squared
  logic [SW-1:0]        sqp2_r [3];
  logic [SW-1:0]        sqq2_r [3];
  logic [SW-1:0]        sqd2_r [3];
  logic signed [SW-1:0] tp2_r  [3];
  logic [2*RW-1:0]      r2_2_r;
  logic signed [SW-1:0] sqp [3];
  logic signed [SW-1:0] sqq [3];
  logic signed [SW-1:0] sqd [3];
  logic signed [SW-1:0] tp  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sqp[i] = p1_r[i] * p1_r[i];
      sqq[i] = q1_r[i] * q1_r[i];
      sqd[i] = d1_r[i] * d1_r[i];
      tp[i]  = p1_r[i] * d1_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqp2_r[i] <= sqp[i];
        sqq2_r[i] <= sqq[i];
        sqd2_r[i] <= sqd[i];
        tp2_r[i]  <= tp[i];
      end
      r2_2_r <= radius_r * radius_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: |AP|^2, |BP|^2, |AB|^2 and projection t
  logic [SW-1:0]        pp3_r;
  logic [SW-1:0]        qq3_r;
  logic [SW-1:0]        dd3_r;
  logic signed [TW-1:0] t3_r;
  logic [2*RW-1:0]      r2_3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pp3_r  <= sqp2_r[0] + sqp2_r[1] + sqp2_r[2];
      qq3_r  <= sqq2_r[0] + sqq2_r[1] + sqq2_r[2];
      dd3_r  <= sqd2_r[0] + sqd2_r[1] + sqd2_r[2];
      t3_r   <= TW'(tp2_r[0]) + TW'(tp2_r[1]) + TW'(tp2_r[2]);
      r2_3_r <= r2_2_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: region decision, endpoint test; wide products start
  region_t region4_nxt;
  logic    inside4_nxt;
  region_t region4_r;
  logic    inside4_r;
  logic [SW-1:0] r2_ext;
  logic [SW-1:0] t_mag;

  assign r2_ext = SW'(r2_3_r);
  // only consumed for interior points, where 0 < t < |AB|^2
  assign t_mag  = t3_r[SW-1:0];

  always_comb begin
    if (t3_r <= 0) begin
      region4_nxt = RGN_START;
      inside4_nxt = (pp3_r <= r2_ext);
    end else if (t3_r >= $signed({1'b0, dd3_r})) begin
      region4_nxt = RGN_END;
      inside4_nxt = (qq3_r <= r2_ext);
    end else begin
      region4_nxt = RGN_INTERIOR;
      inside4_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      region4_r <= region4_nxt;
      inside4_r <= inside4_nxt;
    end
  end

  logic [PW-1:0] ppdd;
  logic [PW-1:0] r2dd;
  logic [PW-1:0] tt;

  pic3d_wide_mul #(.AW(SW)) u_mul_ppdd (
    .clk  (clk),
    .en   (adv),
    .a    (pp3_r),
    .b    (dd3_r),
    .prod (ppdd)
  );

  pic3d_wide_mul #(.AW(SW)) u_mul_r2dd (
    .clk  (clk),
    .en   (adv),
    .a    (r2_ext),
    .b    (dd3_r),
    .prod (r2dd)
  );

  pic3d_wide_mul #(.AW(SW)) u_mul_tt (
    .clk  (clk),
    .en   (adv),
    .a    (t_mag),
    .b    (t_mag),
    .prod (tt)
  );

  // ---------------------------------------------------------------
  // Stage 5: side data waits for the products
  region_t region5_r;
  logic    inside5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      region5_r <= region4_r;
      inside5_r <= inside4_r;
    end
  end

  // ---------------------------------------------------------------
  // Stage 6: interior test |AP|^2|AB|^2 <= r^2|AB|^2 + t^2, output register
  logic [PW:0] rhs;
  logic        inside6_nxt;
  logic        out_inside_r;
  region_t     out_region_r;

  assign rhs = (PW+1)'(r2dd) + (PW+1)'(tt);

  always_comb begin
    if (region5_r == RGN_INTERIOR) begin
      inside6_nxt = ((PW+1)'(ppdd) <= rhs);
    end else begin
      inside6_nxt = inside5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_inside_r <= inside6_nxt;
      out_region_r <= region5_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_region     = out_region_r;

  // ---------------------------------------------------------------
  // Assertions

  // A stall freezes every valid bit in the pipe
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r}))
    else $error("pipeline valid bits moved during a stall");

  // A degenerate segment yields zero projection
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && dd3_r == '0) |-> (t3_r == '0))
    else $error("nonzero projection for zero-length segment");

  // A new result only comes from the last internal stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v5_r))
    else $error("result appeared without a source transaction");

endmodule

`default_nettype wire

/* hw/rtl/pic3d_wide_mul.sv */
`default_nettype none

// Two-stage unsigned multiplier: four half-width partial products are
// registered, then combined into the full product in the second stage.
module pic3d_wide_mul #(
  parameter int AW = 34
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] a,
  input  wire logic [AW-1:0] b,
  output logic [2*AW-1:0]    prod
);

  localparam int HW = (AW + 1) / 2;
  localparam int FW = 4 * HW;

  logic [2*HW-1:0] a_ext;
  logic [2*HW-1:0] b_ext;
  logic [2*HW-1:0] ll_r;
  logic [2*HW-1:0] lh_r;
  logic [2*HW-1:0] hl_r;
  logic [2*HW-1:0] hh_r;
  logic [FW-1:0]   mid;
  logic [FW-1:0]   sum;
  logic [2*AW-1:0] prod_r;

  assign a_ext = (2*HW)'(a);
  assign b_ext = (2*HW)'(b);

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a_ext[HW-1:0]    * b_ext[HW-1:0];
      lh_r <= a_ext[HW-1:0]    * b_ext[2*HW-1:HW];
      hl_r <= a_ext[2*HW-1:HW] * b_ext[HW-1:0];
      hh_r <= a_ext[2*HW-1:HW] * b_ext[2*HW-1:HW];
    end
  end

  // Stage 2: weighted sum of partials
  assign mid = FW'(lh_r) + FW'(hl_r);
  assign sum = FW'(ll_r) + (mid << HW) + (FW'(hh_r) << (2 * HW));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sum[2*AW-1:0];
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

/* bench/point_in_capsule_checker.sv */
// Watches the point, result and configuration ports, predicts every result
// from its own copy of the capsule registers and compares in order.
module point_in_capsule_checker
  import pic3d_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_point_z,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_inside_res,
  input  logic [1:0]                    out_region,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  output int                            open_count,
  output int                            fail_count
);

  typedef struct {
    logic    in_cap;
    region_t region;
  } capsule_result_t;

  // Results still owed by the block, oldest first
  capsule_result_t pending_results[$];
  capsule_result_t oldest;

  // Shadow of the capsule registers
  logic signed [COORD_WIDTH-1:0] seg_start[3];
  logic signed [COORD_WIDTH-1:0] seg_end[3];
  logic [COORD_WIDTH-2:0]        cap_radius;

  int failures = 0;

  initial begin
    open_count = 0;
    fail_count = 0;
  end

  // Exact squared-distance test against the segment, no division
  function automatic capsule_result_t classify_point(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] pz
  );
    longint              pt[3];
    longint              d, p, q;
    longint              len2, dist_a2, dist_b2, proj, rad2;
    logic signed [127:0] w_len2, w_proj, w_rad2, w_dist, lhs, rhs;
    capsule_result_t     res;
    pt[0] = px;
    pt[1] = py;
    pt[2] = pz;
    len2 = 0;
    dist_a2 = 0;
    dist_b2 = 0;
    proj = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'(seg_end[i]) - longint'(seg_start[i]);
      p = pt[i] - longint'(seg_start[i]);
      q = pt[i] - longint'(seg_end[i]);
      len2 += d * d;
      dist_a2 += p * p;
      dist_b2 += q * q;
      proj += p * d;
    end
    rad2 = longint'(cap_radius) * longint'(cap_radius);

    if (proj <= 0) begin
      // behind the start point (also the whole degenerate case)
      res.region = RGN_START;
      res.in_cap = (dist_a2 <= rad2);
    end else if (proj >= len2) begin
      res.region = RGN_END;
      res.in_cap = (dist_b2 <= rad2);
    end else begin
      // interior: |p|^2*|d|^2 <= r^2*|d|^2 + t^2, up to ~70 bits
      w_len2 = len2;
      w_proj = proj;
      w_rad2 = rad2;
      w_dist = dist_a2;
      lhs = w_dist * w_len2;
      rhs = w_rad2 * w_len2 + w_proj * w_proj;
      res.region = RGN_INTERIOR;
      res.in_cap = (lhs <= rhs);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pending_results.delete();
      for (int i = 0; i < 3; i++) begin
        seg_start[i] = '0;
        seg_end[i] = '0;
      end
      cap_radius = '0;
      open_count <= 0;
    end else begin
      // result transaction: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: result with no pending point: inside=%0d region=%0d",
                     $time, out_inside_res, out_region);
        end else begin
          oldest = pending_results.pop_front();
          if (out_inside_res !== oldest.in_cap || out_region !== oldest.region) begin
            failures++;
            if (failures <= 10)
              $display({"%0t: mismatch: expected inside=%0d region=%0d, ",
                        "got inside=%0d region=%0d"},
                       $time, oldest.in_cap, oldest.region, out_inside_res,
                       out_region);
          end
        end
      end

      // point transaction: predict with the registers in force now
      if (in_valid && in_ready)
        pending_results.push_back(classify_point(in_point_x, in_point_y, in_point_z));

      // register writes; unused indexes are dropped
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_START_X: seg_start[0] = cfg_wdata;
          CFG_START_Y: seg_start[1] = cfg_wdata;
          CFG_START_Z: seg_start[2] = cfg_wdata;
          CFG_END_X:   seg_end[0] = cfg_wdata;
          CFG_END_Y:   seg_end[1] = cfg_wdata;
          CFG_END_Z:   seg_end[2] = cfg_wdata;
          CFG_RADIUS:  cap_radius = cfg_wdata[COORD_WIDTH-2:0];
          default: ;
        endcase
      end

      open_count <= pending_results.size();
    end
    fail_count <= failures;
  end

endmodule

/* bench/point_in_capsule_test_top_tb.sv */
// Drives points and capsule settings into the block and gives the verdict.
module point_in_capsule_test_top_tb
  import pic3d_pkg::*;
;

  localparam int CW = COORD_WIDTH_DEF;
  // index past the register map, writes to it must have no effect
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic signed [CW-1:0] in_point_z = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_inside_res;
  logic [1:0]           out_region;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CW-1:0]        cfg_wdata = '0;

  int open_count;
  int fail_count;

  // capsule currently loaded, used to aim points near it
  int cap_a[3];
  int cap_b[3];
  int cap_r;
  bit no_idle = 1'b0;
  int ready_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  point_in_capsule_test_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inside_res(out_inside_res),
    .out_region    (out_region),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  point_in_capsule_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_inside_res(out_inside_res),
    .out_region    (out_region),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .open_count    (open_count),
    .fail_count    (fail_count)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [CW-1:0] to_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CW-1:0];
  endfunction

  // Result side back-pressure: alternating ready runs and stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_left <= 0;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        ready_left <= pick_gap();
      end else begin
        out_ready <= 1'b1;
        ready_left <= $urandom_range(1, 50);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // One point transaction, then an optional gap
  task automatic drive_point(int x, int y, int z);
    int gap;
    in_valid <= 1'b1;
    in_point_x <= to_coord(x);
    in_point_y <= to_coord(y);
    in_point_z <= to_coord(z);
    do @(posedge clk); while (!in_ready);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every owed result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Reprogram the whole capsule while the pipeline is empty
  task automatic load_capsule(int ax, int ay, int az, int bx, int by, int bz,
                              logic [CW-1:0] rad_word);
    wait_idle();
    write_reg(CFG_START_X, to_coord(ax));
    write_reg(CFG_START_Y, to_coord(ay));
    write_reg(CFG_START_Z, to_coord(az));
    write_reg(CFG_END_X, to_coord(bx));
    write_reg(CFG_END_Y, to_coord(by));
    write_reg(CFG_END_Z, to_coord(bz));
    write_reg(CFG_RADIUS, rad_word);
    write_reg(CFG_IDX_SPARE, CW'($urandom()));
    cfg_we <= 1'b0;
    cap_a = '{ax, ay, az};
    cap_b = '{bx, by, bz};
    cap_r = rad_word[CW-2:0];
  endtask

  initial begin
    int mode, k, span;
    int a[3], b[3], pt[3];
    int r;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: segment along x, each region inside and outside
    load_capsule(0, 0, 0, 1000, 0, 0, 16'd100);
    drive_point(-50, 0, 0);
    drive_point(-200, 0, 0);
    drive_point(0, 0, 0);            // projection exactly zero
    drive_point(500, 100, 0);        // on the surface
    drive_point(500, 101, 0);
    drive_point(500, 0, -60);
    drive_point(1000, 0, 0);         // projection equals |AB|^2
    drive_point(1100, 0, 0);
    drive_point(1101, 0, 0);
    drive_point(32767, 32767, 32767);
    drive_point(-32768, -32768, -32768);

    // Degenerate segment acts as a sphere; radius top bit must be dropped
    load_capsule(5, -5, 7, 5, -5, 7, 16'h800a);
    drive_point(5, -5, 7);
    drive_point(15, -5, 7);
    drive_point(16, -5, 7);
    drive_point(-32768, 32767, -32768);

    // Full-range diagonal, largest radius
    load_capsule(-32768, -32768, -32768, 32767, 32767, 32767, 16'hffff);
    drive_point(0, 0, 0);
    drive_point(-1, -1, -1);
    drive_point(32767, -32768, 32767);
    drive_point(-32768, 32767, -32768);
    drive_point(32767, 32767, 32767);
    drive_point(-32768, -32768, -32768);

    // Zero radius: only points on the segment are inside
    load_capsule(-3, 4, -5, 7, 4, -5, 16'd0);
    drive_point(2, 4, -5);
    drive_point(2, 4, -4);
    drive_point(-3, 4, -5);

    // Random phases, each with its own capsule
    for (int ph = 0; ph < 12; ph++) begin
      mode = $urandom_range(0, 4);
      for (int i = 0; i < 3; i++) begin
        case (mode)
          0: begin
            a[i] = int'($urandom_range(0, 65535)) - 32768;
            b[i] = int'($urandom_range(0, 65535)) - 32768;
          end
          1: begin
            a[i] = int'($urandom_range(0, 4000)) - 2000;
            b[i] = a[i] + int'($urandom_range(0, 3000)) - 1500;
          end
          2: begin
            a[i] = int'($urandom_range(0, 65535)) - 32768;
            b[i] = a[i];
          end
          3: begin
            a[i] = $urandom_range(0, 1) ? 32767 : -32768;
            b[i] = $urandom_range(0, 1) ? 32767 : -32768;
          end
          default: begin
            a[i] = int'($urandom_range(0, 40000)) - 20000;
            b[i] = a[i] + int'($urandom_range(0, 6)) - 3;
          end
        endcase
      end
      case (mode)
        0: r = $urandom_range(0, 32767);
        1: r = $urandom_range(0, 800);
        2: r = $urandom_range(0, 3000);
        3: r = $urandom_range(0, 1) ? 32767 : 0;
        default: r = $urandom_range(0, 20);
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      load_capsule(a[0], a[1], a[2], b[0], b[1], b[2],
                   {1'($urandom_range(0, 1)), 15'(r)});

      for (int n = 0; n < 121; n++) begin
        if ($urandom_range(0, 9) < 3) begin
          // anywhere in the coordinate range
          for (int i = 0; i < 3; i++)
            pt[i] = int'($urandom_range(0, 65535)) - 32768;
        end else begin
          // around the capsule, from behind the start to past the end
          k = int'($urandom_range(0, 12)) - 2;
          span = cap_r + cap_r / 8 + 4;
          for (int i = 0; i < 3; i++)
            pt[i] = cap_a[i] + ((cap_b[i] - cap_a[i]) * k) / 8
                    + int'($urandom_range(0, 2 * span)) - span;
        end
        drive_point(pt[0], pt[1], pt[2]);
      end
    end

    // Drain and let the pipeline settle
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
